FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the triangle quality core.
// No dependencies; the bodies are empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define AST_CLK_RST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error(msg);
`define AST_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define AST_CLK_RST(lbl, clk, rstn, prop, msg)
`define AST_CLK(lbl, clk, prop, msg)
`endif
`endif

FILE: rtl/tmaq_pkg.sv
// Package for the triangle minimum-angle quality core: widths, constants,
// the CORDIC angle table and the control struct. No dependencies.
`default_nettype none
package tmaq_pkg;

  localparam int COORD_W       = 32;
  localparam int NUM_FIELDS    = 9;
  localparam int DIFF_W        = COORD_W + 1;
  localparam int MAG_W         = COORD_W;
  localparam int LEN_W         = 6;
  localparam int NORM_BITS     = 15;
  localparam int EDGE_W        = NORM_BITS + 1;
  localparam int PROD_W        = 2 * EDGE_W;
  localparam int DOT_W         = PROD_W + 2;
  localparam int CR_W          = PROD_W;
  localparam int SQ_W          = 2 * (CR_W - 1);
  localparam int SUM_W         = 64;
  localparam int ROOT_W        = 32;
  localparam int ISQ_STAGES    = ROOT_W / 2;
  localparam int CORD_W        = 36;
  localparam int ANG_W         = 26;
  localparam int UANG_W        = 24;
  localparam int CORDIC_STEPS  = 23;
  localparam int ANGLE_ONE_DEG = 65536;

  localparam logic signed [ANG_W-1:0] ANG_90  = ANG_W'(90 * ANGLE_ONE_DEG);
  localparam logic signed [ANG_W-1:0] ANG_180 = ANG_W'(180 * ANGLE_ONE_DEG);
  localparam logic [UANG_W-1:0] ANG_180_U = UANG_W'(180 * ANGLE_ONE_DEG);
  localparam logic [UANG_W-1:0] ANG_60_U  = UANG_W'(60 * ANGLE_ONE_DEG);

  // 60 deg in angle units = SIXTY_ODD * 2^SIXTY_SHIFT
  localparam int SIXTY_SHIFT = 18;
  localparam int SIXTY_ODD   = 15;
  localparam int RECIP_SHIFT = 32;
  localparam logic [RECIP_SHIFT-1:0] RECIP_15 = 32'd286331153;

  typedef struct packed {
    logic vld;
    logic degen;
  } tmaq_ctl_t;

  // atan(2^-i) in 2^-16 degree
  function automatic logic signed [ANG_W-1:0] atan_deg(input int step);
    logic signed [ANG_W-1:0] v;
    case (step)
      0:       v = ANG_W'(2949120);
      1:       v = ANG_W'(1740967);
      2:       v = ANG_W'(919879);
      3:       v = ANG_W'(466945);
      4:       v = ANG_W'(234379);
      5:       v = ANG_W'(117304);
      6:       v = ANG_W'(58666);
      7:       v = ANG_W'(29335);
      8:       v = ANG_W'(14668);
      9:       v = ANG_W'(7334);
      10:      v = ANG_W'(3667);
      11:      v = ANG_W'(1833);
      12:      v = ANG_W'(917);
      13:      v = ANG_W'(458);
      14:      v = ANG_W'(229);
      15:      v = ANG_W'(115);
      16:      v = ANG_W'(57);
      17:      v = ANG_W'(29);
      18:      v = ANG_W'(14);
      19:      v = ANG_W'(7);
      20:      v = ANG_W'(4);
      21:      v = ANG_W'(2);
      22:      v = ANG_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/triangle_min_angle_quality_core.sv
// Pipeline from an accepted request to its result:
// front, square root, CORDIC, quality.
// Throughput: one triangle per cycle; a held result freezes the whole pipeline.
// Reset: synchronous, active low; clears every stage valid bit, data is not reset.
// Depends on tmaq_pkg, tmaq_front, tmaq_isqrt, tmaq_cordic, tmaq_quality.
`default_nettype none
`include "assert_macros.svh"
module triangle_min_angle_quality_core #(
  parameter int QUALITY_FRAC_BITS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // ax, ay, az, bx, by, bz, cx, cy, cz; 32 bits each from bit 0
  input  wire logic [287:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // quality [QUALITY_FRAC_BITS:0], degenerate, zero fill
  output logic [((QUALITY_FRAC_BITS + 9) / 8) * 8 - 1:0] out_tdata
);

  localparam int OUT_W = ((QUALITY_FRAC_BITS + 9) / 8) * 8;
  localparam int QW    = QUALITY_FRAC_BITS + 1;
  localparam logic [QW-1:0] ONE_Q = QW'(1) << QUALITY_FRAC_BITS;

  logic                                    en;
  tmaq_pkg::tmaq_ctl_t                     ctl_in, ctl_f, ctl_out;
  tmaq_pkg::tmaq_ctl_t                     ctl_s [3];
  tmaq_pkg::tmaq_ctl_t                     ctl_c [3];
  logic [3*tmaq_pkg::DOT_W-1:0]            dot_f;
  logic [3*tmaq_pkg::SUM_W-1:0]            sq_f;
  logic [tmaq_pkg::ROOT_W-1:0]             root_s [3];
  logic signed [tmaq_pkg::DOT_W-1:0]       d_s [3];
  logic [3*tmaq_pkg::ANG_W-1:0]            ang_c;
  logic [QW-1:0]                           quality;

  assign en           = !out_tvalid || out_tready;
  assign in_tready    = en;
  assign ctl_in.vld   = in_tvalid && en;
  assign ctl_in.degen = 1'b0;

  tmaq_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .ctl_i (ctl_in),
    .pts_i (in_tdata),
    .ctl_o (ctl_f),
    .dot_o (dot_f),
    .sq_o  (sq_f)
  );

  for (genvar c = 0; c < 3; c++) begin : g_corner
    tmaq_isqrt u_isqrt (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .ctl_i  (ctl_f),
      .s_i    (sq_f[c*tmaq_pkg::SUM_W +: tmaq_pkg::SUM_W]),
      .d_i    (signed'(dot_f[c*tmaq_pkg::DOT_W +: tmaq_pkg::DOT_W])),
      .ctl_o  (ctl_s[c]),
      .root_o (root_s[c]),
      .d_o    (d_s[c])
    );

    tmaq_cordic u_cordic (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .ctl_i  (ctl_s[c]),
      .d_i    (d_s[c]),
      .root_i (root_s[c]),
      .ctl_o  (ctl_c[c]),
      .z_o    (ang_c[c*tmaq_pkg::ANG_W +: tmaq_pkg::ANG_W])
    );
  end

  tmaq_quality #(
    .QUALITY_FRAC_BITS (QUALITY_FRAC_BITS)
  ) u_quality (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .ctl_i     (ctl_c[0]),
    .ang_i     (ang_c),
    .ctl_o     (ctl_out),
    .quality_o (quality)
  );

  assign out_tvalid = ctl_out.vld;
  assign out_tdata  = OUT_W'({ctl_out.degen, quality});

  `AST_CLK_RST(a_lanes_aligned, clk, rst_n, (ctl_c[0].vld == ctl_c[1].vld) && (ctl_c[0].vld == ctl_c[2].vld), "corner lanes out of step")
  `AST_CLK_RST(a_degen_one, clk, rst_n, out_tvalid && ctl_out.degen |-> quality == ONE_Q, "degenerate result without full quality")
  `AST_CLK_RST(a_quality_range, clk, rst_n, out_tvalid |-> quality <= ONE_Q, "quality above one")
  `AST_CLK(a_reset_clears, clk, !rst_n |=> !out_tvalid, "result valid right after reset")

endmodule
`default_nettype wire

FILE: rtl/tmaq_front.sv
// Front pipeline: edge vectors, per-edge normalization, dot products and
// squared cross-product lengths for all three corners. Uses tmaq_pkg.
`default_nettype none
module tmaq_front (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                en,
  input  wire tmaq_pkg::tmaq_ctl_t                 ctl_i,
  input  wire logic [tmaq_pkg::NUM_FIELDS*tmaq_pkg::COORD_W-1:0] pts_i,
  output tmaq_pkg::tmaq_ctl_t                      ctl_o,
  output logic [3*tmaq_pkg::DOT_W-1:0]             dot_o,
  output logic [3*tmaq_pkg::SUM_W-1:0]             sq_o
);

  localparam int NV = 3;
  localparam int NC = 3;
  localparam int NP = 9;

  logic signed [tmaq_pkg::COORD_W-1:0] pt      [NV][NC];
  logic signed [tmaq_pkg::DIFF_W-1:0]  diff_r  [NV][NC];
  logic [tmaq_pkg::MAG_W-1:0]          mag_r   [NV][NC];
  logic [tmaq_pkg::MAG_W-1:0]          mag3_r  [NV][NC];
  logic                                neg_r   [NV][NC];
  logic                                neg3_r  [NV][NC];
  logic [tmaq_pkg::LEN_W-1:0]          len_r   [NV];
  logic signed [tmaq_pkg::EDGE_W-1:0]  nrm_r   [NV][NC];
  logic signed [tmaq_pkg::PROD_W-1:0]  prod_r  [NV][NP];
  logic signed [tmaq_pkg::DOT_W-1:0]   dot6_r  [NV];
  logic signed [tmaq_pkg::DOT_W-1:0]   dot7_r  [NV];
  logic signed [tmaq_pkg::DOT_W-1:0]   dot8_r  [NV];
  logic signed [tmaq_pkg::CR_W-1:0]    cr_r    [NV][NC];
  logic [tmaq_pkg::SQ_W-1:0]           sq_r    [NV][NC];
  logic [tmaq_pkg::SUM_W-1:0]          sum_r   [NV];
  logic [NV-1:0]                       zero_e;
  tmaq_pkg::tmaq_ctl_t                 ctl_r   [8];
  tmaq_pkg::tmaq_ctl_t                 ctl1_nxt;

  function automatic logic [tmaq_pkg::LEN_W-1:0] bit_len(
    input logic [tmaq_pkg::MAG_W-1:0] v);
    logic [tmaq_pkg::LEN_W-1:0] n;
    n = '0;
    for (int i = 0; i < tmaq_pkg::MAG_W; i++) begin
      if (v[i]) n = tmaq_pkg::LEN_W'(i + 1);
    end
    return n;
  endfunction

  function automatic logic signed [tmaq_pkg::EDGE_W-1:0] scale(
    input logic [tmaq_pkg::MAG_W-1:0] m,
    input logic [tmaq_pkg::LEN_W-1:0] len,
    input logic                       neg);
    logic [tmaq_pkg::MAG_W-1:0]  sh;
    logic [tmaq_pkg::EDGE_W-1:0] mg;
    if (len >= tmaq_pkg::LEN_W'(tmaq_pkg::NORM_BITS)) begin
      sh = m >> (len - tmaq_pkg::LEN_W'(tmaq_pkg::NORM_BITS));
    end else begin
      sh = m << (tmaq_pkg::LEN_W'(tmaq_pkg::NORM_BITS) - len);
    end
    mg = {1'b0, sh[tmaq_pkg::NORM_BITS-1:0]};
    return neg ? signed'(-mg) : signed'(mg);
  endfunction

  function automatic logic [tmaq_pkg::CR_W-2:0] abs_cr(
    input logic signed [tmaq_pkg::CR_W-1:0] v);
    logic [tmaq_pkg::CR_W-1:0] a;
    a = v[tmaq_pkg::CR_W-1] ? -v : v;
    return a[tmaq_pkg::CR_W-2:0];
  endfunction

  always_comb begin
    for (int v = 0; v < NV; v++) begin
      for (int k = 0; k < NC; k++) begin
        pt[v][k] = signed'(pts_i[(v*NC+k)*tmaq_pkg::COORD_W +: tmaq_pkg::COORD_W]);
      end
    end
    for (int e = 0; e < NV; e++) begin
      zero_e[e] = (diff_r[e][0] == '0) && (diff_r[e][1] == '0) && (diff_r[e][2] == '0);
    end
    ctl1_nxt.vld   = ctl_r[0].vld;
    ctl1_nxt.degen = |zero_e;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < 8; s++) ctl_r[s] <= '0;
    end else if (en) begin
      ctl_r[0] <= ctl_i;
      ctl_r[1] <= ctl1_nxt;
      for (int s = 2; s < 8; s++) ctl_r[s] <= ctl_r[s-1];
    end
  end

  // edge e runs from vertex e to vertex e+1
  always_ff @(posedge clk) begin
    if (en) begin
      for (int e = 0; e < NV; e++) begin
        for (int k = 0; k < NC; k++) begin
          diff_r[e][k] <= tmaq_pkg::DIFF_W'(pt[(e+1)%NV][k]) - tmaq_pkg::DIFF_W'(pt[e][k]);
          mag_r[e][k]  <= tmaq_pkg::MAG_W'(diff_r[e][k][tmaq_pkg::DIFF_W-1] ?
                                           -diff_r[e][k] : diff_r[e][k]);
          neg_r[e][k]  <= diff_r[e][k][tmaq_pkg::DIFF_W-1];
          mag3_r[e][k] <= mag_r[e][k];
          neg3_r[e][k] <= neg_r[e][k];
          nrm_r[e][k]  <= scale(mag3_r[e][k], len_r[e], neg3_r[e][k]);
        end
        len_r[e] <= bit_len(mag_r[e][0] | mag_r[e][1] | mag_r[e][2]);
      end
      // corner c: u = edge c, w = -edge c+2; sign of w folded in later
      for (int c = 0; c < NV; c++) begin
        prod_r[c][0] <= nrm_r[c][0] * nrm_r[(c+2)%NV][0];
        prod_r[c][1] <= nrm_r[c][1] * nrm_r[(c+2)%NV][1];
        prod_r[c][2] <= nrm_r[c][2] * nrm_r[(c+2)%NV][2];
        prod_r[c][3] <= nrm_r[c][1] * nrm_r[(c+2)%NV][2];
        prod_r[c][4] <= nrm_r[c][2] * nrm_r[(c+2)%NV][1];
        prod_r[c][5] <= nrm_r[c][2] * nrm_r[(c+2)%NV][0];
        prod_r[c][6] <= nrm_r[c][0] * nrm_r[(c+2)%NV][2];
        prod_r[c][7] <= nrm_r[c][0] * nrm_r[(c+2)%NV][1];
        prod_r[c][8] <= nrm_r[c][1] * nrm_r[(c+2)%NV][0];
        dot6_r[c]    <= -(tmaq_pkg::DOT_W'(prod_r[c][0]) + tmaq_pkg::DOT_W'(prod_r[c][1])
                          + tmaq_pkg::DOT_W'(prod_r[c][2]));
        cr_r[c][0]   <= prod_r[c][3] - prod_r[c][4];
        cr_r[c][1]   <= prod_r[c][5] - prod_r[c][6];
        cr_r[c][2]   <= prod_r[c][7] - prod_r[c][8];
        for (int k = 0; k < NC; k++) begin
          sq_r[c][k] <= abs_cr(cr_r[c][k]) * abs_cr(cr_r[c][k]);
        end
        dot7_r[c]    <= dot6_r[c];
        sum_r[c]     <= tmaq_pkg::SUM_W'(sq_r[c][0]) + tmaq_pkg::SUM_W'(sq_r[c][1])
                        + tmaq_pkg::SUM_W'(sq_r[c][2]);
        dot8_r[c]    <= dot7_r[c];
      end
    end
  end

  always_comb begin
    ctl_o = ctl_r[7];
    for (int c = 0; c < NV; c++) begin
      dot_o[c*tmaq_pkg::DOT_W +: tmaq_pkg::DOT_W] = dot8_r[c];
      sq_o[c*tmaq_pkg::SUM_W +: tmaq_pkg::SUM_W]  = sum_r[c];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/tmaq_isqrt.sv
// Pipelined integer square root, two result bits per stage, for one corner.
// Carries the dot product and control alongside. Uses tmaq_pkg.
`default_nettype none
module tmaq_isqrt (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              en,
  input  wire tmaq_pkg::tmaq_ctl_t               ctl_i,
  input  wire logic [tmaq_pkg::SUM_W-1:0]        s_i,
  input  wire logic signed [tmaq_pkg::DOT_W-1:0] d_i,
  output tmaq_pkg::tmaq_ctl_t                    ctl_o,
  output logic [tmaq_pkg::ROOT_W-1:0]            root_o,
  output logic signed [tmaq_pkg::DOT_W-1:0]      d_o
);

  localparam int NS    = tmaq_pkg::ISQ_STAGES;
  localparam int REM_W = tmaq_pkg::ROOT_W + 3;
  localparam int RW    = tmaq_pkg::ROOT_W;
  localparam int SW    = tmaq_pkg::SUM_W;

  logic [REM_W-1:0]                rem_r  [NS];
  logic [RW-1:0]                   root_r [NS];
  logic [SW-1:0]                   n_r    [NS];
  logic signed [tmaq_pkg::DOT_W-1:0] d_r  [NS];
  tmaq_pkg::tmaq_ctl_t             ctl_r  [NS];

  for (genvar j = 0; j < NS; j++) begin : g_stage
    logic [REM_W-1:0]                  rem_p, cat_a, t_a, rem_a, cat_b, t_b, rem_nxt;
    logic [RW-1:0]                     root_p, root_a, root_nxt;
    logic [SW-1:0]                     n_p;
    logic signed [tmaq_pkg::DOT_W-1:0] d_p;
    tmaq_pkg::tmaq_ctl_t               ctl_p;

    if (j == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign n_p    = s_i;
      assign d_p    = d_i;
      assign ctl_p  = ctl_i;
    end else begin : g_next
      assign rem_p  = rem_r[j-1];
      assign root_p = root_r[j-1];
      assign n_p    = n_r[j-1];
      assign d_p    = d_r[j-1];
      assign ctl_p  = ctl_r[j-1];
    end

    always_comb begin
      cat_a = {rem_p[REM_W-3:0], n_p[SW-1 -: 2]};
      t_a   = REM_W'({root_p, 2'b01});
      if (cat_a >= t_a) begin
        rem_a  = cat_a - t_a;
        root_a = {root_p[RW-2:0], 1'b1};
      end else begin
        rem_a  = cat_a;
        root_a = {root_p[RW-2:0], 1'b0};
      end
      cat_b = {rem_a[REM_W-3:0], n_p[SW-3 -: 2]};
      t_b   = REM_W'({root_a, 2'b01});
      if (cat_b >= t_b) begin
        rem_nxt  = cat_b - t_b;
        root_nxt = {root_a[RW-2:0], 1'b1};
      end else begin
        rem_nxt  = cat_b;
        root_nxt = {root_a[RW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[j] <= '0;
      end else if (en) begin
        ctl_r[j] <= ctl_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j]  <= rem_nxt;
        root_r[j] <= root_nxt;
        n_r[j]    <= n_p << 4;
        d_r[j]    <= d_p;
      end
    end
  end

  assign ctl_o  = ctl_r[NS-1];
  assign root_o = root_r[NS-1];
  assign d_o    = d_r[NS-1];

endmodule
`default_nettype wire

FILE: rtl/tmaq_cordic.sv
// Pipelined vectoring CORDIC giving the corner angle in 2^-16 degree from
// the dot product and the cross-product length. Uses tmaq_pkg.
`default_nettype none
module tmaq_cordic (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              en,
  input  wire tmaq_pkg::tmaq_ctl_t               ctl_i,
  input  wire logic signed [tmaq_pkg::DOT_W-1:0] d_i,
  input  wire logic [tmaq_pkg::ROOT_W-1:0]       root_i,
  output tmaq_pkg::tmaq_ctl_t                    ctl_o,
  output logic signed [tmaq_pkg::ANG_W-1:0]      z_o
);

  localparam int NK = tmaq_pkg::CORDIC_STEPS;
  localparam int CW = tmaq_pkg::CORD_W;

  logic signed [CW-1:0]               x_r   [NK+1];
  logic signed [CW-1:0]               y_r   [NK+1];
  logic signed [tmaq_pkg::ANG_W-1:0]  z_r   [NK+1];
  tmaq_pkg::tmaq_ctl_t                ctl_r [NK+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r[0] <= '0;
    end else if (en) begin
      ctl_r[0] <= ctl_i;
    end
  end

  // obtuse corners start turned by 90 deg
  always_ff @(posedge clk) begin
    if (en) begin
      if (d_i < 0) begin
        x_r[0] <= CW'(root_i);
        y_r[0] <= -CW'(d_i);
        z_r[0] <= tmaq_pkg::ANG_90;
      end else begin
        x_r[0] <= CW'(d_i);
        y_r[0] <= CW'(root_i);
        z_r[0] <= '0;
      end
    end
  end

  for (genvar k = 0; k < NK; k++) begin : g_step
    logic signed [CW-1:0]              xs, ys, x_nxt, y_nxt;
    logic signed [tmaq_pkg::ANG_W-1:0] z_nxt;

    always_comb begin
      xs = x_r[k] >>> k;
      ys = y_r[k] >>> k;
      if (y_r[k] > 0) begin
        x_nxt = x_r[k] + ys;
        y_nxt = y_r[k] - xs;
        z_nxt = z_r[k] + tmaq_pkg::atan_deg(k);
      end else if (y_r[k] < 0) begin
        x_nxt = x_r[k] - ys;
        y_nxt = y_r[k] + xs;
        z_nxt = z_r[k] - tmaq_pkg::atan_deg(k);
      end else begin
        x_nxt = x_r[k];
        y_nxt = y_r[k];
        z_nxt = z_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[k+1] <= '0;
      end else if (en) begin
        ctl_r[k+1] <= ctl_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[k+1] <= x_nxt;
        y_r[k+1] <= y_nxt;
        z_r[k+1] <= z_nxt;
      end
    end
  end

  assign ctl_o = ctl_r[NK];
  assign z_o   = z_r[NK];

endmodule
`default_nettype wire

FILE: rtl/tmaq_quality.sv
// Angle clamp, minimum of three corners and the rounded quality ratio by
// reciprocal multiply with one correction step. Uses tmaq_pkg.
`default_nettype none
module tmaq_quality #(
  parameter int QUALITY_FRAC_BITS = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             en,
  input  wire tmaq_pkg::tmaq_ctl_t              ctl_i,
  input  wire logic [3*tmaq_pkg::ANG_W-1:0]     ang_i,
  output tmaq_pkg::tmaq_ctl_t                   ctl_o,
  output logic [QUALITY_FRAC_BITS:0]            quality_o
);

  localparam int QW     = QUALITY_FRAC_BITS + 1;
  localparam int NUM_W  = tmaq_pkg::UANG_W + QUALITY_FRAC_BITS + 1;
  localparam int M_W    = NUM_W - tmaq_pkg::SIXTY_SHIFT;
  localparam int PRQ_W  = M_W + tmaq_pkg::RECIP_SHIFT;
  localparam int UW     = tmaq_pkg::UANG_W;
  localparam logic [NUM_W-1:0] HALF = NUM_W'(tmaq_pkg::ANG_60_U) >> 1;
  localparam logic [M_W-1:0]   ONE_M = M_W'(1) << QUALITY_FRAC_BITS;
  localparam logic [QW-1:0]    ONE_Q = QW'(1) << QUALITY_FRAC_BITS;

  logic [UW-1:0]        ang1_r [3];
  logic [UW-1:0]        mn2_r;
  logic [M_W-1:0]       m3_r, m4_r, q04_r;
  logic                 ge3_r, ge4_r;
  logic [QW-1:0]        q5_r;
  tmaq_pkg::tmaq_ctl_t  ctl1_r, ctl2_r, ctl3_r, ctl4_r, ctl5_r;

  logic [UW-1:0]        diff3;
  logic [NUM_W-1:0]     num3;
  logic [PRQ_W-1:0]     prod4;
  logic [M_W-1:0]       rem5, q5;
  logic [QW-1:0]        q5_nxt;
  logic signed [tmaq_pkg::ANG_W-1:0] z [3];

  always_comb begin
    for (int i = 0; i < 3; i++) z[i] = signed'(ang_i[i*tmaq_pkg::ANG_W +: tmaq_pkg::ANG_W]);
    diff3 = tmaq_pkg::ANG_60_U - mn2_r;
    num3  = (NUM_W'(diff3) << QUALITY_FRAC_BITS) + HALF;
    prod4 = PRQ_W'(m3_r) * PRQ_W'(tmaq_pkg::RECIP_15);
    rem5  = m4_r - ((q04_r << 4) - q04_r);
    q5    = (rem5 >= M_W'(tmaq_pkg::SIXTY_ODD)) ? q04_r + M_W'(1) : q04_r;
    if (ctl4_r.degen) begin
      q5_nxt = ONE_Q;
    end else if (ge4_r) begin
      q5_nxt = '0;
    end else if (q5 > ONE_M) begin
      q5_nxt = ONE_Q;
    end else begin
      q5_nxt = q5[QW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      ctl3_r <= '0;
      ctl4_r <= '0;
      ctl5_r <= '0;
    end else if (en) begin
      ctl1_r <= ctl_i;
      ctl2_r <= ctl1_r;
      ctl3_r <= ctl2_r;
      ctl4_r <= ctl3_r;
      ctl5_r <= ctl4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (z[i] < 0) begin
          ang1_r[i] <= '0;
        end else if (z[i] > tmaq_pkg::ANG_180) begin
          ang1_r[i] <= tmaq_pkg::ANG_180_U;
        end else begin
          ang1_r[i] <= z[i][UW-1:0];
        end
      end
      if (ang1_r[0] <= ang1_r[1] && ang1_r[0] <= ang1_r[2]) begin
        mn2_r <= ang1_r[0];
      end else if (ang1_r[1] <= ang1_r[2]) begin
        mn2_r <= ang1_r[1];
      end else begin
        mn2_r <= ang1_r[2];
      end
      ge3_r <= mn2_r >= tmaq_pkg::ANG_60_U;
      m3_r  <= num3[NUM_W-1:tmaq_pkg::SIXTY_SHIFT];
      q04_r <= prod4[PRQ_W-1:tmaq_pkg::RECIP_SHIFT];
      m4_r  <= m3_r;
      ge4_r <= ge3_r;
      q5_r  <= q5_nxt;
    end
  end

  assign ctl_o     = ctl5_r;
  assign quality_o = q5_r;

endmodule
`default_nettype wire
